// ===== rtl/mdio45_pkg.sv =====
// ----------------------------------------------------------------------------
// MDIO Clause 45 master package
// Item types, frame phase codes and fixed protocol constants.
// ----------------------------------------------------------------------------
package mdio45_pkg;

  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CNT_W     = 6;

  // op codes of an input transaction
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CNT_W-1:0]  PRE_LEN_RST = 6'd32;
  localparam logic [CNT_W-1:0]  FULL_FRAME  = 6'd32;
  localparam logic [CNT_W-1:0]  READ_FRAME  = 6'd14;
  localparam logic [CNT_W-1:0]  DATA_BITS   = 6'd16;
  localparam logic [CNT_W-1:0]  FLUSH_READS = 6'd32;
  localparam logic [DATA_W-1:0] NOACK_VALUE = 16'h5555;

  // start-of-frame and turnaround codes
  localparam logic [3:0] ST_OP_ADDR  = 4'b0000;
  localparam logic [3:0] ST_OP_WRITE = 4'b0001;
  localparam logic [3:0] ST_OP_READ  = 4'b0011;
  localparam logic [1:0] TA_DRIVE    = 2'b10;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_PRE_A  = 8'b0000_0010,
    PH_BODY_A = 8'b0000_0100,
    PH_PRE_D  = 8'b0000_1000,
    PH_BODY_D = 8'b0001_0000,
    PH_TA     = 8'b0010_0000,
    PH_RX     = 8'b0100_0000,
    PH_FLUSH  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic                 op;
    logic                 is_write;
    logic [ADDR_BITS-1:0] phy_address;
    logic [ADDR_BITS-1:0] device_address;
    logic [DATA_W-1:0]    register_address;
    logic [DATA_W-1:0]    write_data;
    logic                 mdio_sample;
  } in_item_t;

  typedef struct packed {
    logic              mdio_level;
    logic              mdio_enable;
    logic              done_res;
    logic [DATA_W-1:0] read_result;
    logic              no_ack;
  } out_item_t;

endpackage

// ===== rtl/mdio45_stream_if.sv =====
// ----------------------------------------------------------------------------
// MDIO Clause 45 master stream interface
// Valid/ready channel carrying one typed item per transaction.
// ----------------------------------------------------------------------------
interface mdio45_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mdio45_seq.sv =====
// ----------------------------------------------------------------------------
// MDIO Clause 45 frame sequencer
// Holds the frame state and advances it by one MDC period per tick.
// ----------------------------------------------------------------------------
module mdio45_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  mdio45_pkg::in_item_t     item,
  input  logic [5:0]               pre_len,
  output mdio45_pkg::out_item_t    res
);

  mdio45_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]  bit_cnt_r, bit_cnt_nxt;
  logic [31:0] tx_shift_r, tx_shift_nxt;
  logic [15:0] rx_shift_r, rx_shift_nxt;
  logic [4:0]  saved_phy_r, saved_phy_nxt;
  logic [4:0]  saved_dev_r, saved_dev_nxt;
  logic [15:0] saved_data_r, saved_data_nxt;
  logic        saved_dir_r, saved_dir_nxt;

  logic [5:0]  cnt_inc;
  logic [31:0] second_frame;

  assign cnt_inc = bit_cnt_r + 6'd1;

  always_comb begin
    if (saved_dir_r) begin
      second_frame = {mdio45_pkg::ST_OP_WRITE, saved_phy_r, saved_dev_r,
                      mdio45_pkg::TA_DRIVE, saved_data_r};
    end else begin
      second_frame = {mdio45_pkg::ST_OP_READ, saved_phy_r, saved_dev_r, 18'd0};
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    tx_shift_nxt   = tx_shift_r;
    rx_shift_nxt   = rx_shift_r;
    saved_phy_nxt  = saved_phy_r;
    saved_dev_nxt  = saved_dev_r;
    saved_data_nxt = saved_data_r;
    saved_dir_nxt  = saved_dir_r;
    res            = '0;
    res.mdio_level = 1'b1;

    if (item.op == mdio45_pkg::OP_START) begin
      if (phase_r == mdio45_pkg::PH_IDLE) begin
        saved_dir_nxt  = item.is_write;
        saved_phy_nxt  = item.phy_address;
        saved_dev_nxt  = item.device_address;
        saved_data_nxt = item.write_data;
        tx_shift_nxt   = {mdio45_pkg::ST_OP_ADDR, item.phy_address, item.device_address,
                          mdio45_pkg::TA_DRIVE, item.register_address};
        rx_shift_nxt   = '0;
        bit_cnt_nxt    = '0;
        phase_nxt      = (pre_len == 6'd0) ? mdio45_pkg::PH_BODY_A : mdio45_pkg::PH_PRE_A;
      end
    end else begin
      unique case (phase_r)
        mdio45_pkg::PH_PRE_A, mdio45_pkg::PH_PRE_D: begin
          res.mdio_enable = 1'b1;
          bit_cnt_nxt     = cnt_inc;
          if (cnt_inc >= pre_len) begin
            bit_cnt_nxt = '0;
            phase_nxt   = (phase_r == mdio45_pkg::PH_PRE_A) ? mdio45_pkg::PH_BODY_A
                                                            : mdio45_pkg::PH_BODY_D;
          end
        end
        mdio45_pkg::PH_BODY_A: begin
          res.mdio_enable = 1'b1;
          res.mdio_level  = tx_shift_r[31];
          tx_shift_nxt    = {tx_shift_r[30:0], 1'b0};
          bit_cnt_nxt     = cnt_inc;
          if (cnt_inc >= mdio45_pkg::FULL_FRAME) begin
            tx_shift_nxt = second_frame;
            bit_cnt_nxt  = '0;
            phase_nxt    = (pre_len == 6'd0) ? mdio45_pkg::PH_BODY_D : mdio45_pkg::PH_PRE_D;
          end
        end
        mdio45_pkg::PH_BODY_D: begin
          res.mdio_enable = 1'b1;
          res.mdio_level  = tx_shift_r[31];
          tx_shift_nxt    = {tx_shift_r[30:0], 1'b0};
          bit_cnt_nxt     = cnt_inc;
          if (saved_dir_r) begin
            // only the release clock remains after the data bits
            if (cnt_inc >= mdio45_pkg::FULL_FRAME) begin
              bit_cnt_nxt = mdio45_pkg::DATA_BITS;
              phase_nxt   = mdio45_pkg::PH_RX;
            end
          end else if (cnt_inc >= mdio45_pkg::READ_FRAME) begin
            bit_cnt_nxt = '0;
            phase_nxt   = mdio45_pkg::PH_TA;
          end
        end
        mdio45_pkg::PH_TA: begin
          bit_cnt_nxt  = '0;
          rx_shift_nxt = '0;
          phase_nxt    = item.mdio_sample ? mdio45_pkg::PH_FLUSH : mdio45_pkg::PH_RX;
        end
        mdio45_pkg::PH_RX: begin
          if (bit_cnt_r < mdio45_pkg::DATA_BITS) begin
            rx_shift_nxt = {rx_shift_r[14:0], item.mdio_sample};
            bit_cnt_nxt  = cnt_inc;
          end else begin
            res.done_res    = 1'b1;
            res.read_result = saved_dir_r ? 16'd0 : rx_shift_r;
            bit_cnt_nxt     = '0;
            phase_nxt       = mdio45_pkg::PH_IDLE;
          end
        end
        mdio45_pkg::PH_FLUSH: begin
          bit_cnt_nxt = cnt_inc;
          if (cnt_inc >= mdio45_pkg::FLUSH_READS) begin
            res.done_res    = 1'b1;
            res.no_ack      = 1'b1;
            res.read_result = mdio45_pkg::NOACK_VALUE;
            bit_cnt_nxt     = '0;
            phase_nxt       = mdio45_pkg::PH_IDLE;
          end
        end
        default: begin
          // idle tick: bus released
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= mdio45_pkg::PH_IDLE;
      bit_cnt_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tx_shift_r   <= tx_shift_nxt;
      rx_shift_r   <= rx_shift_nxt;
      saved_phy_r  <= saved_phy_nxt;
      saved_dev_r  <= saved_dev_nxt;
      saved_data_r <= saved_data_nxt;
      saved_dir_r  <= saved_dir_nxt;
    end
  end

endmodule

// ===== rtl/mdio_clause45_master_unit.sv =====
// ----------------------------------------------------------------------------
// MDIO Clause 45 management master
// Address frame plus write or read frame, stepped one MDC period per tick.
// ----------------------------------------------------------------------------
// Each input transaction is either a start (latch addresses, data and
// direction; ignored while a management access is in progress; gives no
// result) or a tick, which advances the frame by one MDC period and always
// gives exactly one result: the MDIO drive level and enable for that period,
// plus done, read data and no-ack on the completing tick. One transaction is
// taken per clock cycle: the frame state updates in a single pass of short
// logic, and the result sits in one output register. in_ch.ready drops only
// while that register holds a result the sink has not yet taken. The preamble
// length register (reset 32) may be rewritten between accesses.
module mdio_clause45_master_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  mdio45_stream_if.sink          in_ch,
  mdio45_stream_if.source        out_ch,
  input  logic                   cfg_wr_en,
  input  logic [5:0]             cfg_wr_data
);

  logic [5:0]             pre_len_r;
  logic                   out_valid_r;
  mdio45_pkg::out_item_t  out_data_r;
  mdio45_pkg::out_item_t  seq_res;
  mdio45_pkg::in_item_t   in_item;
  logic                   in_fire;

  assign in_item  = in_ch.data;
  // take a new transaction whenever the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // preamble length; the user must write it only between accesses, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_len_r <= mdio45_pkg::PRE_LEN_RST;
    end else if (cfg_wr_en) begin
      pre_len_r <= cfg_wr_data;
    end
  end

  mdio45_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_fire),
    .item    (in_item),
    .pre_len (pre_len_r),
    .res     (seq_res)
  );

  // only ticks produce a result; hold it until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && (in_item.op == mdio45_pkg::OP_TICK)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_item.op == mdio45_pkg::OP_TICK)) begin
      out_data_r <= seq_res;
    end
  end

endmodule
